// ----- rtl/wgsf_pkg.sv -----
// ----------------------------------------------------------------------------
// wgsf_pkg
// shared types and constants of the window grayscale / sepia filter
// ----------------------------------------------------------------------------
package wgsf_pkg;

	// pixel transaction entering the filter
	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} pix_in_t;

	// pixel transaction leaving the filter
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       was_filtered;
	} pix_out_t;

	// first stage contents handed from the front end to the arithmetic pipe
	typedef struct packed {
		logic       valid;
		logic       do_gray;
		logic       do_sepia;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} wgsf_s1_t;

	// filter mode codes
	localparam logic [1:0] MODE_PASS  = 2'd0;
	localparam logic [1:0] MODE_GRAY  = 2'd1;
	localparam logic [1:0] MODE_SEPIA = 2'd2;

	// register indexes of the write port
	localparam logic [2:0] REG_FILTER_MODE = 3'd0;
	localparam logic [2:0] REG_COLOR_IMAGE = 3'd1;
	localparam logic [2:0] REG_SEL_LEFT    = 3'd2;
	localparam logic [2:0] REG_SEL_TOP     = 3'd3;
	localparam logic [2:0] REG_SEL_RIGHT   = 3'd4;
	localparam logic [2:0] REG_SEL_BOTTOM  = 3'd5;

	// sepia matrix in thousandths
	localparam logic [9:0] K_RR = 10'd393;
	localparam logic [9:0] K_RG = 10'd769;
	localparam logic [9:0] K_RB = 10'd189;
	localparam logic [9:0] K_GR = 10'd349;
	localparam logic [9:0] K_GG = 10'd686;
	localparam logic [9:0] K_GB = 10'd168;
	localparam logic [9:0] K_BR = 10'd272;
	localparam logic [9:0] K_BG = 10'd534;
	localparam logic [9:0] K_BB = 10'd131;

	// rounding offset before the divide by 1000
	localparam logic [18:0] SEP_ROUND = 19'd500;
	// accumulator value from which the channel saturates at 255
	localparam logic [18:0] SEP_SAT   = 19'd255500;
	// reciprocal of 1000 scaled by 2^28, exact for accumulators below 2^18
	localparam logic [18:0] RECIP_1000 = 19'd268436;
	localparam int          RECIP_1000_SHIFT = 28;

	// reciprocal of 3 scaled by 2^11, exact for sums below 2048
	localparam logic [9:0] RECIP_3 = 10'd683;
	localparam int         RECIP_3_SHIFT = 11;

	localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage

// ----- rtl/wgsf_core.sv -----
// ----------------------------------------------------------------------------
// wgsf_core
// arithmetic pipe: grayscale average and sepia matrix with rounding and clamp
// ----------------------------------------------------------------------------
module wgsf_core (
	input  logic               clk,
	input  logic               arst_n,
	input  wgsf_pkg::wgsf_s1_t stage1,
	output logic               done,
	output wgsf_pkg::pix_out_t result
);
	import wgsf_pkg::*;

	// stage 2 registers: products
	logic        valid_s2, gray_s2, sepia_s2;
	logic [7:0]  red_s2, green_s2, blue_s2;
	logic [17:0] p_rr_s2, p_rg_s2, p_rb_s2;
	logic [17:0] p_gr_s2, p_gg_s2, p_gb_s2;
	logic [17:0] p_br_s2, p_bg_s2, p_bb_s2;
	logic [18:0] gprod_s2;

	// stage 3 registers: sums
	logic        valid_s3, gray_s3, sepia_s3;
	logic [7:0]  red_s3, green_s3, blue_s3;
	logic [18:0] acc_r_s3, acc_g_s3, acc_b_s3;
	logic [7:0]  avg_s3;

	// stage 4 registers: quotients and saturation flags
	logic        valid_s4, gray_s4, sepia_s4;
	logic [7:0]  red_s4, green_s4, blue_s4;
	logic [7:0]  avg_s4;
	logic [7:0]  q_r_s4, q_g_s4, q_b_s4;
	logic        sat_r_s4, sat_g_s4, sat_b_s4;

	// stage 5 output registers
	logic     valid_s5;
	pix_out_t res_s5;

	logic [9:0]  sum_rgb;
	logic [36:0] qp_r, qp_g, qp_b;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= stage1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// rounded channel sum for the average
	assign sum_rgb = 10'(stage1.red) + 10'(stage1.green) + 10'(stage1.blue) + 10'd1;

	// stage 2: matrix products and scaled sum
	always_ff @(posedge clk) begin
		gray_s2  <= stage1.do_gray;
		sepia_s2 <= stage1.do_sepia;
		red_s2   <= stage1.red;
		green_s2 <= stage1.green;
		blue_s2  <= stage1.blue;
		p_rr_s2  <= stage1.red   * K_RR;
		p_rg_s2  <= stage1.green * K_RG;
		p_rb_s2  <= stage1.blue  * K_RB;
		p_gr_s2  <= stage1.red   * K_GR;
		p_gg_s2  <= stage1.green * K_GG;
		p_gb_s2  <= stage1.blue  * K_GB;
		p_br_s2  <= stage1.red   * K_BR;
		p_bg_s2  <= stage1.green * K_BG;
		p_bb_s2  <= stage1.blue  * K_BB;
		gprod_s2 <= 19'(20'(sum_rgb) * 20'(RECIP_3));
	end

	// stage 3: accumulate with rounding offset, average falls out of the shift
	always_ff @(posedge clk) begin
		gray_s3  <= gray_s2;
		sepia_s3 <= sepia_s2;
		red_s3   <= red_s2;
		green_s3 <= green_s2;
		blue_s3  <= blue_s2;
		acc_r_s3 <= 19'(p_rr_s2) + 19'(p_rg_s2) + 19'(p_rb_s2) + SEP_ROUND;
		acc_g_s3 <= 19'(p_gr_s2) + 19'(p_gg_s2) + 19'(p_gb_s2) + SEP_ROUND;
		acc_b_s3 <= 19'(p_br_s2) + 19'(p_bg_s2) + 19'(p_bb_s2) + SEP_ROUND;
		avg_s3   <= gprod_s2[RECIP_3_SHIFT +: 8];
	end

	// divide by 1000 through the reciprocal, only meaningful below saturation
	assign qp_r = acc_r_s3[17:0] * RECIP_1000;
	assign qp_g = acc_g_s3[17:0] * RECIP_1000;
	assign qp_b = acc_b_s3[17:0] * RECIP_1000;

	// stage 4: quotients and clamp flags
	always_ff @(posedge clk) begin
		gray_s4  <= gray_s3;
		sepia_s4 <= sepia_s3;
		red_s4   <= red_s3;
		green_s4 <= green_s3;
		blue_s4  <= blue_s3;
		avg_s4   <= avg_s3;
		q_r_s4   <= qp_r[RECIP_1000_SHIFT +: 8];
		q_g_s4   <= qp_g[RECIP_1000_SHIFT +: 8];
		q_b_s4   <= qp_b[RECIP_1000_SHIFT +: 8];
		sat_r_s4 <= (acc_r_s3 >= SEP_SAT);
		sat_g_s4 <= (acc_g_s3 >= SEP_SAT);
		sat_b_s4 <= (acc_b_s3 >= SEP_SAT);
	end

	// stage 5: pick the filtered or original pixel
	always_ff @(posedge clk) begin
		if (sepia_s4) begin
			res_s5.red_out   <= sat_r_s4 ? CHAN_MAX : q_r_s4;
			res_s5.green_out <= sat_g_s4 ? CHAN_MAX : q_g_s4;
			res_s5.blue_out  <= sat_b_s4 ? CHAN_MAX : q_b_s4;
		end else if (gray_s4) begin
			res_s5.red_out   <= avg_s4;
			res_s5.green_out <= avg_s4;
			res_s5.blue_out  <= avg_s4;
		end else begin
			res_s5.red_out   <= red_s4;
			res_s5.green_out <= green_s4;
			res_s5.blue_out  <= blue_s4;
		end
		res_s5.was_filtered <= sepia_s4 | gray_s4;
	end

	assign done   = valid_s5;
	assign result = res_s5;

endmodule

// ----- rtl/window_gray_sepia_filter_unit.sv -----
// ----------------------------------------------------------------------------
// window_gray_sepia_filter_unit: grayscale / sepia filter over a selection
// each accepted pixel passes the registers of stages 1 to 5 before done; one pixel accepted every cycle, busy stays low
// done is a one-cycle strobe set by the five-stage pipe; results cannot be held off
// reset clears the valid bits and returns registers to pass through, full-image window
// ----------------------------------------------------------------------------
module window_gray_sepia_filter_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  wgsf_pkg::pix_in_t  pixel,
	output logic               done,
	output wgsf_pkg::pix_out_t result,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_idx,
	input  logic [12:0]        cfg_wdata
);
	import wgsf_pkg::*;

	localparam logic [12:0] SEL_RESET = 13'(MAX_DIM % 8192);

	logic [1:0]  filter_mode_q;
	logic        color_image_q;
	logic [11:0] sel_left_q, sel_top_q;
	logic [12:0] sel_right_q, sel_bottom_q;

	logic     accept;
	logic     in_window;
	logic     active;
	wgsf_s1_t stage_s1;

	// the pipe never stalls
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= MODE_PASS;
			color_image_q <= 1'b0;
			sel_left_q    <= '0;
			sel_top_q     <= '0;
			sel_right_q   <= SEL_RESET;
			sel_bottom_q  <= SEL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_FILTER_MODE: filter_mode_q <= cfg_wdata[1:0];
				REG_COLOR_IMAGE: color_image_q <= cfg_wdata[0];
				REG_SEL_LEFT:    sel_left_q    <= cfg_wdata[11:0];
				REG_SEL_TOP:     sel_top_q     <= cfg_wdata[11:0];
				REG_SEL_RIGHT:   sel_right_q   <= cfg_wdata;
				REG_SEL_BOTTOM:  sel_bottom_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// selection window test
	assign in_window = (pixel.pos_x >= sel_left_q) && (13'(pixel.pos_x) < sel_right_q) &&
	                   (pixel.pos_y >= sel_top_q)  && (13'(pixel.pos_y) < sel_bottom_q);
	assign active = in_window & color_image_q;

	// stage 1: valid bit, pixel and mode decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1.valid    <= accept;
			stage_s1.do_gray  <= active && (filter_mode_q == MODE_GRAY);
			stage_s1.do_sepia <= active && (filter_mode_q == MODE_SEPIA);
			stage_s1.red      <= pixel.red_in;
			stage_s1.green    <= pixel.green_in;
			stage_s1.blue     <= pixel.blue_in;
		end
	end

	wgsf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.stage1 (stage_s1),
		.done   (done),
		.result (result)
	);

	// every accepted transaction leaves as a done strobe once it has passed stages 1 to 5
	a_latency_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted pixel did not produce a result after five cycles");

	a_latency_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result strobe without a matching accepted pixel");

	// a filtered result needs a colour image and an active mode
	a_filter_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.was_filtered) |->
		(color_image_q && (filter_mode_q == MODE_GRAY || filter_mode_q == MODE_SEPIA)))
		else $error("pixel filtered while the configuration disables filtering");

	// grayscale results carry one value on all channels
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.was_filtered && filter_mode_q == MODE_GRAY) |->
		(result.red_out == result.green_out && result.green_out == result.blue_out))
		else $error("grayscale result with differing channels");

endmodule

// ----- tb/tb_window_gray_sepia_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_window_gray_sepia_filter_unit
// drives pixel transactions from a queue through the filter, predicts every
// filtered pixel from a shadow copy of the registers and checks each strobe
// ----------------------------------------------------------------------------
module tb_window_gray_sepia_filter_unit;

	import wgsf_pkg::*;

	// codes that the package does not name
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	// settling time after the last strobe, a little over the pipe depth
	localparam int PIPE_SLACK = 8;
	localparam int RUN_LIMIT  = 4_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	pix_in_t     pixel     = '0;
	logic        done;
	pix_out_t    result;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_idx   = REG_FILTER_MODE;
	logic [12:0] cfg_wdata = '0;

	// shadow of the register file
	logic [1:0]  mode_sh   = MODE_PASS;
	logic        colour_sh = 1'b0;
	logic [11:0] left_sh   = '0;
	logic [11:0] top_sh    = '0;
	logic [12:0] right_sh  = 13'd4096;
	logic [12:0] bottom_sh = 13'd4096;

	pix_in_t  pixel_q[$];
	pix_out_t filtered_q[$];
	int       in_flight    = 0;
	int       mismatch_cnt = 0;
	logic     px_taken     = 1'b0;
	int       gap_left     = 0;
	logic     burst        = 1'b0;

	window_gray_sepia_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one sepia channel: weighted sum in thousandths, round half up, saturate
	function automatic logic [7:0] sepia_tone(int r, int g, int b, int kr, int kg, int kb);
		int acc;
		acc = (kr * r + kg * g + kb * b + 500) / 1000;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	// expected output pixel for the current register settings
	function automatic pix_out_t filter_pixel(pix_in_t p);
		pix_out_t o;
		logic     in_window;
		int       avg;
		o.red_out      = p.red_in;
		o.green_out    = p.green_in;
		o.blue_out     = p.blue_in;
		o.was_filtered = 1'b0;
		in_window = p.pos_x >= left_sh && {1'b0, p.pos_x} < right_sh &&
			p.pos_y >= top_sh && {1'b0, p.pos_y} < bottom_sh;
		if (in_window && colour_sh) begin
			if (mode_sh == MODE_GRAY) begin
				avg = (int'(p.red_in) + int'(p.green_in) + int'(p.blue_in) + 1) / 3;
				o.red_out      = avg[7:0];
				o.green_out    = avg[7:0];
				o.blue_out     = avg[7:0];
				o.was_filtered = 1'b1;
			end else if (mode_sh == MODE_SEPIA) begin
				o.red_out   = sepia_tone(p.red_in, p.green_in, p.blue_in, 393, 769, 189);
				o.green_out = sepia_tone(p.red_in, p.green_in, p.blue_in, 349, 686, 168);
				o.blue_out  = sepia_tone(p.red_in, p.green_in, p.blue_in, 272, 534, 131);
				o.was_filtered = 1'b1;
			end
		end
		return o;
	endfunction

	// driver: holds a pending transaction, otherwise waits out its gap or sends the next
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !px_taken) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left = gap_left - 1;
			start <= 1'b0;
		end else if (pixel_q.size() > 0) begin
			pixel <= pixel_q.pop_front();
			start <= 1'b1;
			in_flight = in_flight + 1;
			gap_left = burst ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 19) == 0)
				burst = !burst;
		end else begin
			start <= 1'b0;
		end
	end

	task automatic check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			mismatch_cnt++;
		end
	endtask

	// monitor: records accepted transactions and checks each result strobe
	always @(posedge clk) begin
		pix_out_t want;
		px_taken = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				filtered_q.push_back(filter_pixel(pixel));
				in_flight = in_flight - 1;
				px_taken = 1'b1;
			end
			if (done) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
					mismatch_cnt++;
				end else begin
					want = filtered_q.pop_front();
					check_field("red_out", want.red_out, result.red_out);
					check_field("green_out", want.green_out, result.green_out);
					check_field("blue_out", want.blue_out, result.blue_out);
					check_field("was_filtered", want.was_filtered, result.was_filtered);
				end
			end
		end
	end

	task automatic queue_px(int x, int y, int r, int g, int b);
		pix_in_t p;
		p.pos_x    = x[11:0];
		p.pos_y    = y[11:0];
		p.red_in   = r[7:0];
		p.green_in = g[7:0];
		p.blue_in  = b[7:0];
		pixel_q.push_back(p);
	endtask

	// wait until every sent transaction has come back, then let the pipe settle
	task automatic drain();
		while (pixel_q.size() != 0 || in_flight != 0 || filtered_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// register write, masked into the shadow as the block keeps it
	task automatic write_reg(logic [2:0] idx, logic [12:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_FILTER_MODE: mode_sh   = data[1:0];
			REG_COLOR_IMAGE: colour_sh = data[0];
			REG_SEL_LEFT:    left_sh   = data[11:0];
			REG_SEL_TOP:     top_sh    = data[11:0];
			REG_SEL_RIGHT:   right_sh  = data;
			REG_SEL_BOTTOM:  bottom_sh = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic finish_writes();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic phase_config(int mode, int colour, int l, int t, int r, int b);
		drain();
		write_reg(REG_FILTER_MODE, mode[12:0]);
		write_reg(REG_COLOR_IMAGE, colour[12:0]);
		write_reg(REG_SEL_LEFT, l[12:0]);
		write_reg(REG_SEL_TOP, t[12:0]);
		write_reg(REG_SEL_RIGHT, r[12:0]);
		write_reg(REG_SEL_BOTTOM, b[12:0]);
		finish_writes();
	endtask

	// channel value with extra weight on the extremes
	function automatic int pick_channel();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 255 : 0;
		return $urandom_range(0, 255);
	endfunction

	// stimulus and end of run
	initial begin
		int ph;
		int n;
		int sel;
		int wkind;
		int wl;
		int wt;
		int wr;
		int wb;
		int x;
		int y;
		int pmode;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: pass through over the full image
		queue_px(0, 0, 0, 0, 0);
		queue_px(4095, 4095, 255, 255, 255);

		// grayscale, rounding of the average
		phase_config(MODE_GRAY, 1, 0, 0, 4096, 4096);
		queue_px(0, 0, 0, 0, 0);
		queue_px(4095, 4095, 255, 255, 255);
		queue_px(1, 1, 1, 0, 0);
		queue_px(2, 2, 1, 1, 0);
		queue_px(5, 5, 255, 254, 0);

		// sepia, including saturation of the red and green channels
		phase_config(MODE_SEPIA, 1, 0, 0, 4096, 4096);
		queue_px(0, 0, 255, 255, 255);
		queue_px(4095, 0, 0, 0, 0);
		queue_px(7, 9, 10, 50, 200);
		queue_px(0, 4095, 0, 255, 0);

		// spare mode passes through
		phase_config(MODE_SPARE, 1, 0, 0, 4096, 4096);
		queue_px(3, 3, 200, 100, 50);

		// grey image marker disables the filter
		phase_config(MODE_SEPIA, 0, 0, 0, 4096, 4096);
		queue_px(3, 3, 200, 100, 50);

		// small window, every edge on both sides
		phase_config(MODE_SEPIA, 1, 10, 20, 30, 40);
		queue_px(9, 20, 90, 80, 70);
		queue_px(10, 20, 90, 80, 70);
		queue_px(29, 39, 90, 80, 70);
		queue_px(30, 39, 90, 80, 70);
		queue_px(29, 40, 90, 80, 70);
		queue_px(10, 19, 90, 80, 70);

		// inverted window: nothing inside
		phase_config(MODE_GRAY, 1, 30, 40, 10, 20);
		queue_px(15, 25, 90, 80, 70);

		// wide write values are truncated; window reaching past the image
		drain();
		write_reg(REG_FILTER_MODE, 13'h1FFE);
		write_reg(REG_COLOR_IMAGE, 13'h1FFF);
		write_reg(REG_SEL_LEFT, 13'h1FFF);
		write_reg(REG_SEL_TOP, 13'h1FFF);
		write_reg(REG_SEL_RIGHT, 13'h1FFF);
		write_reg(REG_SEL_BOTTOM, 13'h1FFF);
		finish_writes();
		queue_px(4095, 4095, 128, 64, 32);
		queue_px(4094, 4095, 128, 64, 32);

		// writes to unused indexes change nothing
		drain();
		write_reg(REG_SPARE_A, 13'h1FFF);
		write_reg(REG_SPARE_B, '0);
		finish_writes();
		queue_px(4095, 4095, 1, 2, 3);

		// random phases, mostly filtering windows with pixels around their edges
		for (ph = 0; ph < 10; ph++) begin
			sel = $urandom_range(0, 7);
			pmode = (sel == 0) ? MODE_PASS : (sel < 4) ? MODE_GRAY :
				(sel < 7) ? MODE_SEPIA : MODE_SPARE;
			wkind = $urandom_range(0, 7);
			if (wkind == 0) begin
				wl = 0; wt = 0; wr = 4096; wb = 4096;
			end else if (wkind == 1) begin
				wr = $urandom_range(1, 4095);
				wl = $urandom_range(wr, 4095);
				wb = $urandom_range(1, 4095);
				wt = $urandom_range(wb, 4095);
			end else begin
				wl = $urandom_range(0, 4095);
				wt = $urandom_range(0, 4095);
				wr = wl + $urandom_range(1, (wkind == 2) ? 4096 : 300);
				wb = wt + $urandom_range(1, (wkind == 2) ? 4096 : 300);
				if (wr > 4096) wr = 4096;
				if (wb > 4096) wb = 4096;
			end
			phase_config(pmode, $urandom_range(0, 7) != 0, wl, wt, wr, wb);
			for (n = 0; n < 50; n++) begin
				if (wkind != 1 && $urandom_range(0, 3) != 0) begin
					x = $urandom_range((wl > 2) ? wl - 2 : 0, (wr > 4094) ? 4095 : wr + 1);
					y = $urandom_range((wt > 2) ? wt - 2 : 0, (wb > 4094) ? 4095 : wb + 1);
				end else begin
					x = $urandom_range(0, 4095);
					y = $urandom_range(0, 4095);
				end
				queue_px(x, y, pick_channel(), pick_channel(), pick_channel());
			end
		end

		drain();
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#RUN_LIMIT;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- window_gray_sepia_filter_unit.f -----
rtl/wgsf_pkg.sv
rtl/wgsf_core.sv
rtl/window_gray_sepia_filter_unit.sv
tb/tb_window_gray_sepia_filter_unit.sv
